[rtl/assert_macros.svh]
// Assertion macros used by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define CISD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that an antecedent is followed by a consequent in the next cycle.
`define CISD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cisd_pkg.sv]
// Types and constants of the compressed integer stream decoder.
package cisd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 3;

  localparam logic [ByteW-1:0] LEAD_ONE_MASK  = 8'h80;
  localparam logic [ByteW-1:0] LEAD_TWO_MASK  = 8'hC0;
  localparam logic [ByteW-1:0] LEAD_FOUR_MASK = 8'hE0;
  localparam logic [ByteW-1:0] LEAD_WORD      = 8'hF0;
  localparam logic [ByteW-1:0] LEAD_MAX_LESS1 = 8'hFE;
  localparam logic [ByteW-1:0] LEAD_MAX       = 8'hFF;

  localparam logic [CountW-1:0] CONT_TWO  = 3'd1;
  localparam logic [CountW-1:0] CONT_FOUR = 3'd3;
  localparam logic [CountW-1:0] CONT_WORD = 3'd4;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_LEAD = 1'b1;

  typedef struct packed {
    logic [CountW-1:0] bytes_left;
    logic [ValueW-1:0] acc;
    logic              little_endian;
  } state_t;

  typedef struct packed {
    logic              fire;
    logic [ValueW-1:0] uval;
    logic [ValueW-1:0] sval;
    logic              status;
  } result_t;

endpackage

[rtl/compressed_int_stream_decoder.sv]
// A result is offered in the cycle after the item carrying its last byte is accepted.
// Takes one byte item per cycle unless a result waits untaken; decode is combinational.
// A value takes one to five byte items depending on its lead byte.
// The output register lets a new byte in whenever the pending result is being taken.
// Synchronous active-low reset clears the decoder state and the output valid flag.
module compressed_int_stream_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cisd_pkg::ByteW-1:0]          in_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cisd_pkg::ValueW-1:0]         out_unsigned_value,
  output logic signed [cisd_pkg::ValueW-1:0]  out_signed_value,
  output logic                                out_status
);
  import cisd_pkg::*;
  `include "assert_macros.svh"

  state_t            state_r, state_nxt;
  result_t           step_res;
  logic              out_valid_r, out_valid_nxt;
  logic [ValueW-1:0] uval_r, sval_r;
  logic              status_r;
  logic              in_fire;

  cisd_decode u_decode (
    .state_i  (state_r),
    .byte_i   (in_byte),
    .state_o  (state_nxt),
    .result_o (step_res)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = step_res.fire;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && step_res.fire) begin
      uval_r   <= step_res.uval;
      sval_r   <= step_res.sval;
      status_r <= step_res.status;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_unsigned_value = uval_r;
  assign out_signed_value   = $signed(sval_r);
  assign out_status         = status_r;

  `CISD_ASSERT(a_err_zero, !out_valid_r || status_r == STATUS_OK || (uval_r == '0 && sval_r == '0), "error result carries a non-zero value")
  `CISD_ASSERT(a_count_range, state_r.bytes_left <= CONT_WORD, "continuation count out of range")
  `CISD_ASSERT(a_word_form, !state_r.little_endian || state_r.bytes_left != '0, "word form flag set while awaiting a lead byte")
  `CISD_ASSERT_NEXT(a_no_mid_result, in_fire && state_r.bytes_left > 3'd1, !out_valid_r, "result raised by a middle continuation byte")

endmodule

[rtl/cisd_decode.sv]
// Per-byte decode step: next decoder state and the result the byte completes.
module cisd_decode (
  input  cisd_pkg::state_t             state_i,
  input  logic [cisd_pkg::ByteW-1:0]   byte_i,
  output cisd_pkg::state_t             state_o,
  output cisd_pkg::result_t            result_o
);
  import cisd_pkg::*;

  logic [1:0]        lane;
  logic [ValueW-1:0] placed;
  logic [ValueW-1:0] merged;
  logic [CountW-1:0] left_dec;
  logic              emit;
  logic              bad;
  logic [ValueW-1:0] value;

  function automatic logic [ValueW-1:0] signed_form(input logic [ValueW-1:0] u);
    logic [ValueW-1:0] mag;
    mag = {1'b0, u[ValueW-1:1]};
    if (&u) begin
      signed_form = {1'b1, {(ValueW-1){1'b0}}};
    end else if (u[0]) begin
      signed_form = ~mag;
    end else begin
      signed_form = mag;
    end
  endfunction

  // Byte lane of a continuation byte: the word form fills from the bottom up.
  always_comb begin
    if (state_i.little_endian) begin
      lane = 2'(CONT_WORD - state_i.bytes_left);
    end else begin
      lane = 2'(state_i.bytes_left - 3'd1);
    end
    case (lane)
      2'd0:    placed = {24'd0, byte_i};
      2'd1:    placed = {16'd0, byte_i, 8'd0};
      2'd2:    placed = {8'd0, byte_i, 16'd0};
      2'd3:    placed = {byte_i, 24'd0};
      default: placed = '0;
    endcase
    merged   = state_i.acc | placed;
    left_dec = state_i.bytes_left - 3'd1;
  end

  always_comb begin
    state_o = state_i;
    emit    = 1'b0;
    bad     = 1'b0;
    value   = '0;
    if (state_i.bytes_left != '0) begin
      state_o.acc        = merged;
      state_o.bytes_left = left_dec;
      if (left_dec == '0) begin
        state_o.little_endian = 1'b0;
        emit                  = 1'b1;
        value                 = merged;
      end
    end else if ((byte_i & LEAD_ONE_MASK) == '0) begin
      emit  = 1'b1;
      value = {24'd0, byte_i};
    end else if ((byte_i & LEAD_TWO_MASK) == LEAD_ONE_MASK) begin
      state_o.acc           = {18'd0, byte_i[5:0], 8'd0};
      state_o.little_endian = 1'b0;
      state_o.bytes_left    = CONT_TWO;
    end else if ((byte_i & LEAD_FOUR_MASK) == LEAD_TWO_MASK) begin
      state_o.acc           = {3'd0, byte_i[4:0], 24'd0};
      state_o.little_endian = 1'b0;
      state_o.bytes_left    = CONT_FOUR;
    end else if (byte_i == LEAD_WORD) begin
      state_o.acc           = '0;
      state_o.little_endian = 1'b1;
      state_o.bytes_left    = CONT_WORD;
    end else if (byte_i == LEAD_MAX_LESS1) begin
      emit  = 1'b1;
      value = {{(ValueW-1){1'b1}}, 1'b0};
    end else if (byte_i == LEAD_MAX) begin
      emit  = 1'b1;
      value = '1;
    end else begin
      // Unknown lead byte: report it and fall back to the reset state.
      state_o = '0;
      emit    = 1'b1;
      bad     = 1'b1;
    end
  end

  assign result_o.fire   = emit;
  assign result_o.uval   = value;
  assign result_o.sval   = signed_form(value);
  assign result_o.status = bad ? STATUS_BAD_LEAD : STATUS_OK;

endmodule
